/* hw/rtl/lcdws_pkg.sv */
// Shared types, codes and constants for the character-LCD write sequencer.
// No dependencies; used by every other file except lcdws_if and lcdws_checker.
`timescale 1ns / 1ps

package lcdws_pkg;

    localparam int MAX_DIGITS_DEF = 5;
    localparam int NUM_W          = 16;

    localparam logic [4:0] DEC_BASE      = 5'd10;
    localparam logic [3:0] CHAR_DIGIT_HI = 4'h3;   // upper nibble of ASCII '0'..'9'

    // floor(x / 10) == (x * 0xCCCD) >> 19 for every x below 2^18
    localparam logic [15:0] DIV10_RECIP = 16'hCCCD;
    localparam int          DIV10_SHIFT = 19;

    localparam logic [3:0] HOLD_CMD_HI = 4'd5;
    localparam logic [3:0] HOLD_CMD_LO = 4'd5;
    localparam logic [3:0] HOLD_CHR_HI = 4'd10;
    localparam logic [3:0] HOLD_NONE   = 4'd0;

    localparam logic [2:0] ROW_LAST = 3'd3;

    typedef enum logic [2:0] {
        REQ_CMD     = 3'd0,
        REQ_CHAR    = 3'd1,
        REQ_CURSOR  = 3'd2,
        REQ_CHAR_AT = 3'd3,
        REQ_NUM_AT  = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        JOB_CURSOR,
        JOB_BYTE,
        JOB_DIGIT
    } t_job;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIG_START,
        ST_DIG_WAIT,
        ST_SEND,
        ST_STATUS
    } t_state;

    typedef struct packed {
        logic [7:0] data;
        logic       en;
        logic [3:0] hold;
        logic       last_phase;
    } t_snap;

    typedef struct packed {
        logic       pin_event;
        logic       reg_select;
        logic [7:0] data_bus;
        logic       enable_level;
        logic [3:0] hold_us;
        logic       row_error;
        logic       last_result;
    } t_res;

    function automatic logic [7:0] row_base(input logic [1:0] row);
        logic [7:0] base;
        case (row)
            2'd0:    base = 8'h80;
            2'd1:    base = 8'hC0;
            2'd2:    base = 8'h94;
            2'd3:    base = 8'hD4;
            default: base = 8'h80;
        endcase
        return base;
    endfunction

endpackage

/* hw/rtl/lcdws_if.sv */
// Handshake channels of the LCD write sequencer: request, result, configuration.
// Depends on nothing; carries valid, ready and the payload of each channel.
`timescale 1ns / 1ps

interface lcdws_req_if;
    logic        valid;
    logic        ready;
    logic [2:0]  req_type;
    logic [7:0]  byte_value;
    logic [15:0] number_value;
    logic [2:0]  row_index;
    logic [7:0]  column_index;

    modport source (output valid, req_type, byte_value, number_value, row_index,
                    column_index, input ready);
    modport sink   (input valid, req_type, byte_value, number_value, row_index,
                    column_index, output ready);
endinterface

interface lcdws_res_if;
    logic       valid;
    logic       ready;
    logic       pin_event;
    logic       reg_select;
    logic [7:0] data_bus;
    logic       enable_level;
    logic [3:0] hold_us;
    logic       row_error;
    logic       last_result;

    modport source (output valid, pin_event, reg_select, data_bus, enable_level,
                    hold_us, row_error, last_result, input ready);
    modport sink   (input valid, pin_event, reg_select, data_bus, enable_level,
                    hold_us, row_error, last_result, output ready);
endinterface

interface lcdws_cfg_if;
    logic valid;
    logic ready;
    logic bus_mode;

    modport source (output valid, bus_mode, input ready);
    modport sink   (input valid, bus_mode, output ready);
endinterface

/* hw/rtl/lcdws_div10.sv */
// Shared divide-by-ten unit: reciprocal multiply, then multiply-subtract for the
// remainder (stages r_mul, r_sub, r_done). Depends on lcdws_pkg for the constants.
`timescale 1ns / 1ps

module lcdws_div10 (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [lcdws_pkg::NUM_W-1:0]  i_dividend,
    output logic                         o_done,
    output logic [lcdws_pkg::NUM_W-1:0]  o_quot,
    output logic [3:0]                   o_rem
);

    localparam int W      = lcdws_pkg::NUM_W;
    localparam int PROD_W = 2 * W;

    logic              r_mul;
    logic              r_sub;
    logic              r_done;
    logic [W-1:0]      r_num;
    logic [W-1:0]      r_quo;
    logic [3:0]        r_rem;
    logic [PROD_W-1:0] prod;
    logic [W-1:0]      tens;
    logic [W-1:0]      diff;

    assign prod = {{W{1'b0}}, r_num} * {{W{1'b0}}, lcdws_pkg::DIV10_RECIP};
    assign tens = r_quo * W'(lcdws_pkg::DEC_BASE);
    assign diff = r_num - tens;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul  <= 1'b0;
            r_sub  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_mul  <= i_start;
            r_sub  <= r_mul;
            r_done <= r_sub;
        end
        if (i_start) begin
            r_num <= i_dividend;
        end
        if (r_mul) begin
            r_quo <= W'(prod >> lcdws_pkg::DIV10_SHIFT);
        end
        // remainder is below ten, so the low nibble carries it
        if (r_sub) begin
            r_rem <= diff[3:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

/* hw/rtl/lcdws_snap.sv */
// Pin snapshot formatter: strobe phase of one byte in four- or eight-bit mode.
// Depends on lcdws_pkg for hold times and the snapshot struct.
`timescale 1ns / 1ps

module lcdws_snap (
    input  logic                 i_rs,
    input  logic [7:0]           i_value,
    input  logic                 i_wide,
    input  logic [1:0]           i_phase,
    output lcdws_pkg::t_snap     o_snap
);

    logic [3:0] hold_hi;
    logic [3:0] hold_lo;

    assign hold_hi = i_rs ? lcdws_pkg::HOLD_CHR_HI : lcdws_pkg::HOLD_CMD_HI;
    assign hold_lo = i_rs ? lcdws_pkg::HOLD_NONE   : lcdws_pkg::HOLD_CMD_LO;

    always_comb begin
        o_snap.en         = ~i_phase[0];
        o_snap.last_phase = 1'b0;
        if (i_wide) begin
            o_snap.data       = i_value;
            o_snap.hold       = i_phase[0] ? lcdws_pkg::HOLD_NONE : hold_hi;
            o_snap.last_phase = i_phase[0];
        end else begin
            // high nibble on phases 0/1, low nibble on phases 2/3
            o_snap.data       = {4'h0, i_phase[1] ? i_value[3:0] : i_value[7:4]};
            o_snap.hold       = i_phase[0] ? hold_lo : hold_hi;
            o_snap.last_phase = i_phase[1] & i_phase[0];
        end
    end

endmodule

/* hw/rtl/char_lcd_write_sequencer_unit.sv */
// Top level of the character-LCD write sequencer: request decode, digit
// extraction and snapshot sequencing. Uses lcdws_pkg, lcdws_if, lcdws_div10, lcdws_snap.
//
//  Port     Dir  Handshake        Payload
//  i_req    in   valid / ready    req_type, byte_value, number_value, row_index, column_index
//  o_res    out  valid / ready    pin_event, reg_select, data_bus, enable_level, hold_us,
//                                 row_error, last_result
//  i_cfg    in   valid / ready    bus_mode (ready always high)
//
//  One request is taken in the idle state; one result snapshot leaves per cycle while o_res
//  is ready (2 per byte at eight bits, 4 at four bits). A number first passes through the
//  shared divide-by-ten unit, one digit at a time and for at most MAX_DIGITS digits.
//  Reset (synchronous, active low) returns to idle, empties the result register and
//  clears bus_mode. A stalled o_res holds its result and freezes snapshot sequencing.
`timescale 1ns / 1ps

module char_lcd_write_sequencer_unit #(
    parameter int MAX_DIGITS = lcdws_pkg::MAX_DIGITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lcdws_req_if.sink   i_req,
    lcdws_res_if.source o_res,
    lcdws_cfg_if.sink   i_cfg
);

    localparam int CNT_W = $clog2(MAX_DIGITS + 1);
    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

    lcdws_pkg::t_state           r_state, n_state;
    lcdws_pkg::t_job             r_job, n_job;
    logic [2:0]                  r_type, n_type;
    logic [7:0]                  r_byte, n_byte;
    logic [1:0]                  r_row, n_row;
    logic [7:0]                  r_col, n_col;
    logic                        r_row_err, n_row_err;
    logic [lcdws_pkg::NUM_W-1:0] r_val, n_val;
    logic [CNT_W-1:0]            r_ndig, n_ndig;
    logic [IDX_W-1:0]            r_dsel, n_dsel;
    logic [1:0]                  r_phase, n_phase;
    logic                        r_bus_mode;
    logic                        r_out_valid, n_out_valid;
    lcdws_pkg::t_res             r_out, n_out;
    logic [3:0]                  r_dig [MAX_DIGITS];

    logic                        div_start;
    logic                        div_done;
    logic [lcdws_pkg::NUM_W-1:0] div_quot;
    logic [3:0]                  div_rem;
    logic                        row_bad;
    logic                        slot_free;
    logic                        cur_rs;
    logic [7:0]                  cur_value;
    logic                        more;
    logic [CNT_W-1:0]            ndig_dec;
    lcdws_pkg::t_snap            snap;

    lcdws_div10 u_div10 (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_val),
        .o_done     (div_done),
        .o_quot     (div_quot),
        .o_rem      (div_rem)
    );

    lcdws_snap u_snap (
        .i_rs    (cur_rs),
        .i_value (cur_value),
        .i_wide  (r_bus_mode),
        .i_phase (r_phase),
        .o_snap  (snap)
    );

    assign i_req.ready = (r_state == lcdws_pkg::ST_IDLE);
    assign i_cfg.ready = 1'b1;
    assign row_bad     = (i_req.row_index > lcdws_pkg::ROW_LAST);
    assign slot_free   = !r_out_valid || o_res.ready;
    assign ndig_dec    = r_ndig - 1'b1;

    // byte currently on its way out
    always_comb begin
        case (r_job)
            lcdws_pkg::JOB_CURSOR: begin
                cur_rs    = 1'b0;
                cur_value = lcdws_pkg::row_base(r_row) + r_col;
            end
            lcdws_pkg::JOB_BYTE: begin
                cur_rs    = (r_type != lcdws_pkg::REQ_CMD);
                cur_value = r_byte;
            end
            lcdws_pkg::JOB_DIGIT: begin
                cur_rs    = 1'b1;
                cur_value = {lcdws_pkg::CHAR_DIGIT_HI, r_dig[r_dsel]};
            end
            default: begin
                cur_rs    = 1'b0;
                cur_value = 8'h00;
            end
        endcase
    end

    always_comb begin
        case (r_job)
            lcdws_pkg::JOB_CURSOR: more = (r_type != lcdws_pkg::REQ_CURSOR);
            lcdws_pkg::JOB_DIGIT:  more = (r_dsel != '0);
            default:               more = 1'b0;
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_job       = r_job;
        n_type      = r_type;
        n_byte      = r_byte;
        n_row       = r_row;
        n_col       = r_col;
        n_row_err   = r_row_err;
        n_val       = r_val;
        n_ndig      = r_ndig;
        n_dsel      = r_dsel;
        n_phase     = r_phase;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_res.ready;
        div_start   = 1'b0;

        case (r_state)
            lcdws_pkg::ST_IDLE: begin
                if (i_req.valid) begin
                    n_type    = i_req.req_type;
                    n_byte    = i_req.byte_value;
                    n_row     = i_req.row_index[1:0];
                    n_col     = i_req.column_index;
                    n_val     = i_req.number_value;
                    n_ndig    = '0;
                    n_phase   = 2'd0;
                    n_row_err = 1'b0;
                    case (i_req.req_type)
                        lcdws_pkg::REQ_CMD, lcdws_pkg::REQ_CHAR: begin
                            n_job   = lcdws_pkg::JOB_BYTE;
                            n_state = lcdws_pkg::ST_SEND;
                        end
                        lcdws_pkg::REQ_CURSOR: begin
                            n_row_err = row_bad;
                            n_job     = lcdws_pkg::JOB_CURSOR;
                            n_state   = row_bad ? lcdws_pkg::ST_STATUS : lcdws_pkg::ST_SEND;
                        end
                        lcdws_pkg::REQ_CHAR_AT: begin
                            n_row_err = row_bad;
                            n_job     = row_bad ? lcdws_pkg::JOB_BYTE : lcdws_pkg::JOB_CURSOR;
                            n_state   = lcdws_pkg::ST_SEND;
                        end
                        lcdws_pkg::REQ_NUM_AT: begin
                            n_row_err = row_bad;
                            n_state   = lcdws_pkg::ST_DIG_START;
                        end
                        default: begin
                            // unknown type: drop without result
                            n_state = lcdws_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            lcdws_pkg::ST_DIG_START: begin
                // zero still yields one digit, as the first pass is always taken
                if (r_ndig == '0 ||
                    (r_val != '0 && r_ndig < CNT_W'(MAX_DIGITS))) begin
                    div_start = 1'b1;
                    n_state   = lcdws_pkg::ST_DIG_WAIT;
                end else begin
                    n_dsel  = ndig_dec[IDX_W-1:0];
                    n_job   = r_row_err ? lcdws_pkg::JOB_DIGIT : lcdws_pkg::JOB_CURSOR;
                    n_state = lcdws_pkg::ST_SEND;
                end
            end
            lcdws_pkg::ST_DIG_WAIT: begin
                if (div_done) begin
                    n_val   = div_quot;
                    n_ndig  = r_ndig + 1'b1;
                    n_state = lcdws_pkg::ST_DIG_START;
                end
            end
            lcdws_pkg::ST_SEND: begin
                if (slot_free) begin
                    n_out_valid        = 1'b1;
                    n_out.pin_event    = 1'b1;
                    n_out.reg_select   = cur_rs;
                    n_out.data_bus     = snap.data;
                    n_out.enable_level = snap.en;
                    n_out.hold_us      = snap.hold;
                    n_out.last_result  = snap.last_phase && !more;
                    n_out.row_error    = snap.last_phase && !more && r_row_err;
                    if (!snap.last_phase) begin
                        n_phase = r_phase + 1'b1;
                    end else begin
                        n_phase = 2'd0;
                        if (!more) begin
                            n_state = lcdws_pkg::ST_IDLE;
                        end else if (r_job == lcdws_pkg::JOB_DIGIT) begin
                            n_dsel = r_dsel - 1'b1;
                        end else if (r_type == lcdws_pkg::REQ_CHAR_AT) begin
                            n_job = lcdws_pkg::JOB_BYTE;
                        end else begin
                            n_job = lcdws_pkg::JOB_DIGIT;
                        end
                    end
                end
            end
            lcdws_pkg::ST_STATUS: begin
                if (slot_free) begin
                    n_out_valid       = 1'b1;
                    n_out             = '0;
                    n_out.row_error   = 1'b1;
                    n_out.last_result = 1'b1;
                    n_state           = lcdws_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = lcdws_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lcdws_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_bus_mode  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid) begin
                r_bus_mode <= i_cfg.bus_mode;
            end
        end
        r_job     <= n_job;
        r_type    <= n_type;
        r_byte    <= n_byte;
        r_row     <= n_row;
        r_col     <= n_col;
        r_row_err <= n_row_err;
        r_val     <= n_val;
        r_ndig    <= n_ndig;
        r_dsel    <= n_dsel;
        r_phase   <= n_phase;
        r_out     <= n_out;
    end

    // store each remainder, least significant digit first
    always_ff @(posedge i_clk) begin
        if (r_state == lcdws_pkg::ST_DIG_WAIT && div_done) begin
            r_dig[r_ndig[IDX_W-1:0]] <= div_rem;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.pin_event    = r_out.pin_event;
    assign o_res.reg_select   = r_out.reg_select;
    assign o_res.data_bus     = r_out.data_bus;
    assign o_res.enable_level = r_out.enable_level;
    assign o_res.hold_us      = r_out.hold_us;
    assign o_res.row_error    = r_out.row_error;
    assign o_res.last_result  = r_out.last_result;

endmodule

/* hw/rtl/lcdws_checker.sv */
// Port-level checks for the LCD write sequencer, bound to the top level.
// Depends on char_lcd_write_sequencer_unit and its channel interfaces.
`timescale 1ns / 1ps

module lcdws_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_res_valid,
    input logic       i_res_ready,
    input logic       i_pin_event,
    input logic       i_reg_select,
    input logic [7:0] i_data_bus,
    input logic       i_enable_level,
    input logic [3:0] i_hold_us,
    input logic       i_row_error,
    input logic       i_last_result
);

    // a stalled result stays valid with its data, strobe level, hold and last flag unchanged
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=>
            i_res_valid && $stable(i_data_bus) && $stable(i_last_result)
            && $stable(i_enable_level) && $stable(i_hold_us))
        else $error("stalled result changed");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_row_error |-> i_last_result)
        else $error("row error away from last result");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_pin_event |->
            i_row_error && i_last_result && i_data_bus == 8'h00
            && !i_enable_level && !i_reg_select && i_hold_us == 4'd0)
        else $error("malformed status result");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && i_pin_event |->
            (i_enable_level && (i_hold_us == 4'd5 || i_hold_us == 4'd10))
            || (!i_enable_level && (i_hold_us == 4'd0 || i_hold_us == 4'd5)))
        else $error("hold time does not match strobe level");

endmodule

bind char_lcd_write_sequencer_unit lcdws_checker u_lcdws_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_pin_event    (o_res.pin_event),
    .i_reg_select   (o_res.reg_select),
    .i_data_bus     (o_res.data_bus),
    .i_enable_level (o_res.enable_level),
    .i_hold_us      (o_res.hold_us),
    .i_row_error    (o_res.row_error),
    .i_last_result  (o_res.last_result)
);

/* tb/sv/char_lcd_write_sequencer_unit_checker.sv */
// Checker for the character-LCD write sequencer: watches the request, result and
// bus-mode channels, predicts every pin snapshot and compares. Uses lcdws_pkg, lcdws_if.
`timescale 1ns / 1ps

module char_lcd_write_sequencer_unit_checker #(
    parameter int MAX_DIGITS = lcdws_pkg::MAX_DIGITS_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    lcdws_req_if  req_mon,
    lcdws_res_if  res_mon,
    lcdws_cfg_if  cfg_mon,
    output int    o_fail_count,
    output int    o_pending
);
    import lcdws_pkg::*;

    localparam logic [7:0] CHAR_ZERO      = "0";
    localparam logic [7:0] ROW_ADDR [4]   = '{8'h80, 8'hC0, 8'h94, 8'hD4};
    localparam int unsigned RADIX         = 10;
    localparam int         REPORT_MAX     = 10;

    logic wide_bus;
    t_res snap_q[$];      // expected snapshots, oldest first
    t_res burst_q[$];     // snapshots of the request being decoded
    int   fails;
    int   reported;

    initial begin
        fails        = 0;
        reported     = 0;
        wide_bus     = 1'b0;
    end

    function automatic void add_snap(input logic rs, input logic [7:0] data,
                                     input logic en, input logic [3:0] hold);
        t_res s;
        s              = '0;
        s.pin_event    = 1'b1;
        s.reg_select   = rs;
        s.data_bus     = data;
        s.enable_level = en;
        s.hold_us      = hold;
        burst_q.push_back(s);
    endfunction

    function automatic void add_byte(input logic rs, input logic [7:0] value);
        logic [3:0] hi_hold;
        logic [3:0] lo_hold;
        hi_hold = rs ? HOLD_CHR_HI : HOLD_CMD_HI;
        lo_hold = (rs || wide_bus) ? HOLD_NONE : HOLD_CMD_LO;
        if (wide_bus) begin
            add_snap(rs, value, 1'b1, hi_hold);
            add_snap(rs, value, 1'b0, lo_hold);
        end else begin
            // high nibble first, each nibble strobed high then low
            add_snap(rs, {4'h0, value[7:4]}, 1'b1, hi_hold);
            add_snap(rs, {4'h0, value[7:4]}, 1'b0, lo_hold);
            add_snap(rs, {4'h0, value[3:0]}, 1'b1, hi_hold);
            add_snap(rs, {4'h0, value[3:0]}, 1'b0, lo_hold);
        end
    endfunction

    function automatic logic add_cursor(input logic [2:0] row, input logic [7:0] col);
        logic [7:0] addr;
        if (row > ROW_LAST) return 1'b0;
        addr = ROW_ADDR[row[1:0]] + col;
        add_byte(1'b0, addr);
        return 1'b1;
    endfunction

    function automatic void add_number(input logic [15:0] num);
        logic [7:0]  digs [MAX_DIGITS];
        int          n;
        int unsigned v;
        n = 0;
        v = num;
        if (v == 0) begin
            add_byte(1'b1, CHAR_ZERO);
            return;
        end
        while (v > 0 && n < MAX_DIGITS) begin
            digs[n] = CHAR_ZERO + 8'(v % RADIX);
            v       = v / RADIX;
            n++;
        end
        while (n > 0) begin
            n--;
            add_byte(1'b1, digs[n]);
        end
    endfunction

    function automatic void predict_request(input logic [2:0] kind, input logic [7:0] code,
                                            input logic [15:0] num, input logic [2:0] row,
                                            input logic [7:0] col);
        logic ok;
        t_res tail;
        ok = 1'b1;
        burst_q.delete();
        case (kind)
            REQ_CMD:     add_byte(1'b0, code);
            REQ_CHAR:    add_byte(1'b1, code);
            REQ_CURSOR:  ok = add_cursor(row, col);
            REQ_CHAR_AT: begin
                ok = add_cursor(row, col);
                add_byte(1'b1, code);
            end
            REQ_NUM_AT: begin
                ok = add_cursor(row, col);
                add_number(num);
            end
            default:     return;
        endcase
        // a lone bad-row cursor move still reports one status-only result
        if (burst_q.size() == 0) burst_q.push_back('0);
        tail             = burst_q.pop_back();
        tail.row_error   = !ok;
        tail.last_result = 1'b1;
        burst_q.push_back(tail);
        foreach (burst_q[i]) snap_q.push_back(burst_q[i]);
    endfunction

    always @(posedge i_clk) begin : watch
        t_res act;
        t_res want;
        if (!i_rst_n) begin
            snap_q.delete();
            wide_bus = 1'b0;
        end else begin
            if (cfg_mon.valid && cfg_mon.ready) wide_bus = cfg_mon.bus_mode;
            if (req_mon.valid && req_mon.ready) begin
                predict_request(req_mon.req_type, req_mon.byte_value, req_mon.number_value,
                                req_mon.row_index, req_mon.column_index);
            end
            if (res_mon.valid && res_mon.ready) begin
                act.pin_event    = res_mon.pin_event;
                act.reg_select   = res_mon.reg_select;
                act.data_bus     = res_mon.data_bus;
                act.enable_level = res_mon.enable_level;
                act.hold_us      = res_mon.hold_us;
                act.row_error    = res_mon.row_error;
                act.last_result  = res_mon.last_result;
                if (snap_q.size() == 0) begin
                    fails++;
                    if (reported < REPORT_MAX) begin
                        reported++;
                        $display("chk: unexpected snapshot pe=%0d rs=%0d data=%02h en=%0d",
                                 act.pin_event, act.reg_select, act.data_bus,
                                 act.enable_level);
                    end
                end else begin
                    want = snap_q.pop_front();
                    if (act != want) begin
                        fails++;
                        if (reported < REPORT_MAX) begin
                            reported++;
                            $display("chk: exp pe=%0d rs=%0d d=%02h en=%0d h=%0d e=%0d l=%0d",
                                     want.pin_event, want.reg_select, want.data_bus,
                                     want.enable_level, want.hold_us, want.row_error,
                                     want.last_result);
                            $display("chk: act pe=%0d rs=%0d d=%02h en=%0d h=%0d e=%0d l=%0d",
                                     act.pin_event, act.reg_select, act.data_bus,
                                     act.enable_level, act.hold_us, act.row_error,
                                     act.last_result);
                        end
                    end
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= snap_q.size();
    end

endmodule

/* tb/sv/char_lcd_write_sequencer_unit_tb.sv */
// Testbench top for the character-LCD write sequencer: clock, reset, requests,
// bus-mode writes and result back-pressure. Uses lcdws_pkg, lcdws_if and the checker.
`timescale 1ns / 1ps

module char_lcd_write_sequencer_unit_tb;
    import lcdws_pkg::*;

    localparam int RESET_CYCLES  = 11;
    localparam int SETTLE_CYCLES = 150;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PHASE_ITEMS   = 27;

    logic i_clk     = 1'b0;
    logic i_rst_n;
    logic res_ready = 1'b0;
    bit   quiet_mode;
    int   stall_left;
    int   cycle_count;
    int   fail_count;
    int   pending;

    lcdws_req_if req_if ();
    lcdws_res_if res_if ();
    lcdws_cfg_if cfg_if ();

    assign res_if.ready = res_ready;

    char_lcd_write_sequencer_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_res   (res_if),
        .i_cfg   (cfg_if)
    );

    char_lcd_write_sequencer_unit_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req_mon      (req_if),
        .res_mon      (res_if),
        .cfg_mon      (cfg_if),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_mode || r < 40) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // back-pressure on the result side
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            res_ready  <= 1'b0;
        end else if (!quiet_mode && $urandom_range(0, 99) < 20) begin
            stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(9, 39)
                                                      : $urandom_range(0, 2);
            res_ready  <= 1'b0;
        end else begin
            res_ready <= 1'b1;
        end
    end

    task automatic send_req(input logic [2:0] kind, input logic [7:0] code,
                            input logic [15:0] num, input logic [2:0] row,
                            input logic [7:0] col);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.req_type     <= kind;
        req_if.byte_value   <= code;
        req_if.number_value <= num;
        req_if.row_index    <= row;
        req_if.column_index <= col;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    // hold requests until every snapshot is out, then let an ignored request settle
    task automatic wait_idle();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_bus_mode(input logic wide);
        wait_idle();
        cfg_if.valid    <= 1'b1;
        cfg_if.bus_mode <= wide;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        cfg_if.valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_number();
        case ($urandom_range(0, 4))
            0:       return 16'd0;
            1:       return 16'($urandom_range(1, 99));
            2:       return 16'($urandom_range(100, 9999));
            3:       return 16'($urandom);
            default: return 16'(65535 - $urandom_range(0, 9));
        endcase
    endfunction

    task automatic run_random(input int count);
        logic [2:0] kind;
        logic [2:0] row;
        logic [7:0] col;
        int         done;
        done = 0;
        while (done < count) begin
            kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                : 3'($urandom_range(0, 4));
            row  = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(4, 7))
                                               : 3'($urandom_range(0, 3));
            col  = ($urandom_range(0, 7) == 0) ? {8{1'($urandom)}} : 8'($urandom);
            send_req(kind, 8'($urandom), pick_number(), row, col);
            if (kind <= REQ_NUM_AT) done++;
        end
    endtask

    initial begin
        i_rst_n             <= 1'b0;
        quiet_mode          <= 1'b0;
        req_if.valid        <= 1'b0;
        req_if.req_type     <= REQ_CMD;
        req_if.byte_value   <= 8'h00;
        req_if.number_value <= 16'h0000;
        req_if.row_index    <= 3'd0;
        req_if.column_index <= 8'h00;
        cfg_if.valid        <= 1'b0;
        cfg_if.bus_mode     <= 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed pass on the four-bit bus left by reset
        send_req(REQ_CMD,     8'h00, 16'd0,     3'd0, 8'h00);
        send_req(REQ_CMD,     8'hFF, 16'd0,     3'd0, 8'h00);
        send_req(REQ_CHAR,    8'hA5, 16'd0,     3'd0, 8'h00);
        send_req(REQ_CHAR,    8'h5A, 16'd0,     3'd0, 8'h00);
        send_req(REQ_CURSOR,  8'h00, 16'd0,     3'd0, 8'h00);
        send_req(REQ_CURSOR,  8'h00, 16'd0,     3'd3, 8'hFF);
        send_req(REQ_CURSOR,  8'h00, 16'd0,     3'd1, 8'h40);
        send_req(REQ_CURSOR,  8'h00, 16'd0,     3'd4, 8'h12);
        send_req(REQ_CURSOR,  8'h00, 16'd0,     3'd7, 8'hFF);
        send_req(REQ_CHAR_AT, 8'h41, 16'd0,     3'd2, 8'h05);
        send_req(REQ_CHAR_AT, 8'h7E, 16'd0,     3'd5, 8'h00);
        send_req(REQ_NUM_AT,  8'h00, 16'd0,     3'd0, 8'h00);
        send_req(REQ_NUM_AT,  8'h00, 16'hFFFF,  3'd1, 8'h0F);
        send_req(REQ_NUM_AT,  8'h00, 16'd10000, 3'd2, 8'h00);
        send_req(REQ_NUM_AT,  8'h00, 16'd9,     3'd3, 8'h27);
        send_req(REQ_NUM_AT,  8'h00, 16'd1234,  3'd6, 8'h00);
        send_req(REQ_NUM_AT,  8'h00, 16'd100,   3'd0, 8'hFF);
        send_req(3'd5,        8'hFF, 16'hFFFF,  3'd7, 8'hFF);
        send_req(3'd7,        8'h00, 16'd0,     3'd0, 8'h00);
        send_req(REQ_CHAR,    8'h00, 16'd0,     3'd0, 8'h00);

        set_bus_mode(1'b1);
        run_random(PHASE_ITEMS);
        // no idling on either side for this phase
        quiet_mode <= 1'b1;
        set_bus_mode(1'b0);
        run_random(PHASE_ITEMS);
        quiet_mode <= 1'b0;
        set_bus_mode(1'b1);
        run_random(PHASE_ITEMS);
        set_bus_mode(1'b0);
        run_random(PHASE_ITEMS);

        wait_idle();
        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
